/* rtl/qrs_pkg.sv */
package qrs_pkg;

    // Number of real roots reported with a result
    typedef enum logic [1:0] {
        ROOTS_NONE = 2'd0,
        ROOTS_ONE  = 2'd1,
        ROOTS_TWO  = 2'd2
    } root_cnt_t;

    // Per-item control that rides along the pipeline next to the data
    typedef struct packed {
        root_cnt_t count;
        logic      degen;
    } root_ctl_t;

endpackage

/* rtl/quadratic_root_solver_top.sv */
// Real roots of a*x^2 + b*x + c in signed fixed point (COEF_WIDTH bits, FRAC_BITS
// fraction bits). Each s_ transaction carries a, b, c; each m_ transaction gives
// the root count, the two roots (-b -/+ floor(sqrt(b*b-4ac)))/(2a) truncated toward
// zero, a degenerate flag for a == 0 and a saturated flag for clamped roots. One
// coefficient set is accepted every clock; each passes through the discriminant
// front end and the bit-per-stage square root and divider pipelines. The whole
// pipeline holds while a result waits on m_tready.
module quadratic_root_solver_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // coef_a, coef_b, coef_c
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // root_count, root_minus, root_plus, degenerate, saturated
    output logic [((2*COEF_WIDTH+4+7)/8)*8-1:0]   m_tdata
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int RAD_W  = 2 * W + 2;
    localparam int QW     = W + 1 + F;
    localparam int DEN_W  = W + 1;
    localparam int CTL_W  = $bits(root_ctl_t);
    localparam int SB1_W  = 1 + W + (W + 1) + CTL_W;
    localparam int SB2_W  = CTL_W + 2;
    localparam int OUT_W  = 2 * W + 4;
    localparam int M_DW   = ((2*COEF_WIDTH+4+7)/8)*8;
    localparam logic [QW-1:0] LIM_POS = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = LIM_POS + 1'b1;

    // global advance: move when the output slot is free or being taken
    logic ce;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] out_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // discriminant front end
    logic               d_vld;
    logic [RAD_W-1:0]   d_disc;
    logic               d_a_neg;
    logic [W-1:0]       d_a_mag;
    logic [W:0]         d_nb;
    root_ctl_t          d_ctl;

    qrs_disc #(.W(W)) u_disc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (s_tvalid && s_tready),
        .coef_a  (s_tdata[W-1:0]),
        .coef_b  (s_tdata[2*W-1:W]),
        .coef_c  (s_tdata[3*W-1:2*W]),
        .out_vld (d_vld),
        .disc    (d_disc),
        .a_neg   (d_a_neg),
        .a_mag   (d_a_mag),
        .nb      (d_nb),
        .ctl     (d_ctl)
    );

    // square root of the discriminant
    logic               q_vld;
    logic [W:0]         q_root;
    logic [SB1_W-1:0]   q_sb;
    logic               q_a_neg;
    logic [W-1:0]       q_a_mag;
    logic [W:0]         q_nb;
    root_ctl_t          q_ctl;

    qrs_sqrt #(.RAD_W(RAD_W), .SB_W(SB1_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (d_vld),
        .rad     (d_disc),
        .in_sb   ({d_a_neg, d_a_mag, d_nb, d_ctl}),
        .out_vld (q_vld),
        .root    (q_root),
        .out_sb  (q_sb)
    );

    assign {q_a_neg, q_a_mag, q_nb, q_ctl} = q_sb;

    // numerators -b -/+ s in sign-magnitude, scaled by the fraction bits
    logic [W+1:0] n_m, n_p;
    logic [W:0]   mag_m, mag_p;

    always_comb begin
        n_m   = {q_nb[W], q_nb} - {1'b0, q_root};
        n_p   = {q_nb[W], q_nb} + {1'b0, q_root};
        mag_m = n_m[W+1] ? (~n_m[W:0] + 1'b1) : n_m[W:0];
        mag_p = n_p[W+1] ? (~n_p[W:0] + 1'b1) : n_p[W:0];
    end

    logic             p_vld_reg;
    logic [QW-1:0]    p_num_m_reg, p_num_p_reg;
    logic [DEN_W-1:0] p_den_reg;
    logic             p_neg_m_reg, p_neg_p_reg;
    root_ctl_t        p_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (ce) begin
            p_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_num_m_reg <= {mag_m, {F{1'b0}}};
            p_num_p_reg <= {mag_p, {F{1'b0}}};
            p_den_reg   <= {q_a_mag, 1'b0};
            p_neg_m_reg <= n_m[W+1] ^ q_a_neg;
            p_neg_p_reg <= n_p[W+1] ^ q_a_neg;
            p_ctl_reg   <= q_ctl;
        end
    end

    // both quotients by 2|a|
    logic             v_vld;
    logic [QW-1:0]    quo_m, quo_p;
    logic [SB2_W-1:0] v_sb;
    root_ctl_t        v_ctl;
    logic             v_neg_m, v_neg_p;

    qrs_div #(.NUM_W(QW), .DEN_W(DEN_W), .SB_W(SB2_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (p_vld_reg),
        .num_a   (p_num_m_reg),
        .num_b   (p_num_p_reg),
        .den     (p_den_reg),
        .in_sb   ({p_ctl_reg, p_neg_m_reg, p_neg_p_reg}),
        .out_vld (v_vld),
        .quo_a   (quo_m),
        .quo_b   (quo_p),
        .out_sb  (v_sb)
    );

    assign {v_ctl, v_neg_m, v_neg_p} = v_sb;

    // clamp, apply sign, blank unused roots
    logic         sat_m, sat_p, sat_any;
    logic [W-1:0] cm_mag, cp_mag, rm, rp, out_m, out_p;

    always_comb begin
        sat_m  = quo_m > (v_neg_m ? LIM_NEG : LIM_POS);
        sat_p  = quo_p > (v_neg_p ? LIM_NEG : LIM_POS);
        cm_mag = sat_m ? (v_neg_m ? LIM_NEG[W-1:0] : LIM_POS[W-1:0]) : quo_m[W-1:0];
        cp_mag = sat_p ? (v_neg_p ? LIM_NEG[W-1:0] : LIM_POS[W-1:0]) : quo_p[W-1:0];
        rm     = v_neg_m ? (~cm_mag + 1'b1) : cm_mag;
        rp     = v_neg_p ? (~cp_mag + 1'b1) : cp_mag;
        case (v_ctl.count)
            ROOTS_ONE: begin
                out_m   = rm;
                out_p   = '0;
                sat_any = sat_m;
            end
            ROOTS_TWO: begin
                out_m   = rm;
                out_p   = rp;
                sat_any = sat_m | sat_p;
            end
            default: begin
                out_m   = '0;
                out_p   = '0;
                sat_any = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= v_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= {sat_any, v_ctl.degen, out_p, out_m, v_ctl.count};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DW-OUT_W){1'b0}}, out_reg};

endmodule

/* rtl/qrs_disc.sv */
module qrs_disc #(
    parameter int W = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  logic                   in_vld,
    input  logic [W-1:0]           coef_a,
    input  logic [W-1:0]           coef_b,
    input  logic [W-1:0]           coef_c,
    output logic                   out_vld,
    output logic [2*W+1:0]         disc,
    output logic                   a_neg,
    output logic [W-1:0]           a_mag,
    output logic [W:0]             nb,
    output qrs_pkg::root_ctl_t     ctl
);
    import qrs_pkg::*;

    // stage 1: sign and magnitude of each coefficient
    logic           vld1_reg;
    logic           a_neg1_reg, b_neg1_reg, c_neg1_reg;
    logic [W-1:0]   a_mag1_reg, b_mag1_reg, c_mag1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_neg1_reg <= coef_a[W-1];
            b_neg1_reg <= coef_b[W-1];
            c_neg1_reg <= coef_c[W-1];
            a_mag1_reg <= coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
            b_mag1_reg <= coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
            c_mag1_reg <= coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
        end
    end

    // stage 2: products b*b and a*c, and -b
    logic           vld2_reg;
    logic [2*W-1:0] bb2_reg, ac2_reg;
    logic           a_neg2_reg, add2_reg, a_nz2_reg;
    logic [W-1:0]   a_mag2_reg;
    logic [W:0]     nb2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (ce) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            bb2_reg    <= b_mag1_reg * b_mag1_reg;
            ac2_reg    <= a_mag1_reg * c_mag1_reg;
            a_neg2_reg <= a_neg1_reg;
            a_mag2_reg <= a_mag1_reg;
            a_nz2_reg  <= (a_mag1_reg != '0);
            // opposite signs of a and c: -4ac adds to b*b
            add2_reg   <= (a_neg1_reg != c_neg1_reg) && (c_mag1_reg != '0);
            nb2_reg    <= b_neg1_reg ? {1'b0, b_mag1_reg} : (~{1'b0, b_mag1_reg} + 1'b1);
        end
    end

    // stage 3: discriminant and root count
    logic [2*W+1:0] bbx, ac4, d_sum, d_diff;
    root_ctl_t      ctl_next;
    logic [2*W+1:0] disc_next;

    always_comb begin
        bbx    = {2'b00, bb2_reg};
        ac4    = {ac2_reg, 2'b00};
        d_sum  = bbx + ac4;
        d_diff = bbx - ac4;
        ctl_next.degen = !a_nz2_reg;
        if (!a_nz2_reg) begin
            ctl_next.count = ROOTS_NONE;
        end else if (add2_reg || (bbx > ac4)) begin
            ctl_next.count = ROOTS_TWO;
        end else if (bbx == ac4) begin
            ctl_next.count = ROOTS_ONE;
        end else begin
            ctl_next.count = ROOTS_NONE;
        end
        // only two distinct roots need a square root
        if (ctl_next.count != ROOTS_TWO) begin
            disc_next = '0;
        end else if (add2_reg) begin
            disc_next = d_sum;
        end else begin
            disc_next = d_diff;
        end
    end

    logic           vld3_reg;
    logic [2*W+1:0] disc3_reg;
    logic           a_neg3_reg;
    logic [W-1:0]   a_mag3_reg;
    logic [W:0]     nb3_reg;
    root_ctl_t      ctl3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            disc3_reg  <= disc_next;
            a_neg3_reg <= a_neg2_reg;
            a_mag3_reg <= a_mag2_reg;
            nb3_reg    <= nb2_reg;
            ctl3_reg   <= ctl_next;
        end
    end

    assign out_vld = vld3_reg;
    assign disc    = disc3_reg;
    assign a_neg   = a_neg3_reg;
    assign a_mag   = a_mag3_reg;
    assign nb      = nb3_reg;
    assign ctl     = ctl3_reg;

endmodule

/* rtl/qrs_sqrt.sv */
module qrs_sqrt #(
    parameter int RAD_W = 66,
    parameter int SB_W  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_vld,
    input  logic [RAD_W-1:0]     rad,
    input  logic [SB_W-1:0]      in_sb,
    output logic                 out_vld,
    output logic [RAD_W/2-1:0]   root,
    output logic [SB_W-1:0]      out_sb
);
    // one root bit per stage, restoring digit recurrence
    localparam int N  = RAD_W / 2;
    localparam int RW = N + 2;

    logic             vld_reg  [1:N];
    logic [RW-1:0]    rem_reg  [1:N];
    logic [N-1:0]     root_reg [1:N];
    logic [RAD_W-1:0] rad_reg  [1:N];
    logic [SB_W-1:0]  sb_reg   [1:N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic             vld_in;
        logic [RW-1:0]    rem_in;
        logic [N-1:0]     root_in;
        logic [RAD_W-1:0] rad_in;
        logic [SB_W-1:0]  sb_in;
        logic [RW+1:0]    cur, trial;
        logic             take;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign sb_in   = in_sb;
        end else begin : g_next
            assign vld_in  = vld_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
            assign sb_in   = sb_reg[k];
        end

        assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1]  <= take ? RW'(cur - trial) : RW'(cur);
                root_reg[k+1] <= {root_in[N-2:0], take};
                rad_reg[k+1]  <= {rad_in[RAD_W-3:0], 2'b00};
                sb_reg[k+1]   <= sb_in;
            end
        end
    end

    assign out_vld = vld_reg[N];
    assign root    = root_reg[N];
    assign out_sb  = sb_reg[N];

endmodule

/* rtl/qrs_div.sv */
module qrs_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33,
    parameter int SB_W  = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num_a,
    input  logic [NUM_W-1:0]  num_b,
    input  logic [DEN_W-1:0]  den,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_vld,
    output logic [NUM_W-1:0]  quo_a,
    output logic [NUM_W-1:0]  quo_b,
    output logic [SB_W-1:0]   out_sb
);
    // two restoring dividers sharing one divisor, one quotient bit per stage
    logic             vld_reg  [1:NUM_W];
    logic [NUM_W-1:0] na_reg   [1:NUM_W];
    logic [NUM_W-1:0] nbv_reg  [1:NUM_W];
    logic [DEN_W-1:0] ra_reg   [1:NUM_W];
    logic [DEN_W-1:0] rb_reg   [1:NUM_W];
    logic [NUM_W-1:0] qa_reg   [1:NUM_W];
    logic [NUM_W-1:0] qb_reg   [1:NUM_W];
    logic [DEN_W-1:0] den_reg  [1:NUM_W];
    logic [SB_W-1:0]  sb_reg   [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             vld_in;
        logic [NUM_W-1:0] na_in, nb_in, qa_in, qb_in;
        logic [DEN_W-1:0] ra_in, rb_in, den_in;
        logic [SB_W-1:0]  sb_in;
        logic [DEN_W:0]   cur_a, cur_b;
        logic             take_a, take_b;

        if (k == 0) begin : g_first
            assign vld_in = in_vld;
            assign na_in  = num_a;
            assign nb_in  = num_b;
            assign ra_in  = '0;
            assign rb_in  = '0;
            assign qa_in  = '0;
            assign qb_in  = '0;
            assign den_in = den;
            assign sb_in  = in_sb;
        end else begin : g_next
            assign vld_in = vld_reg[k];
            assign na_in  = na_reg[k];
            assign nb_in  = nbv_reg[k];
            assign ra_in  = ra_reg[k];
            assign rb_in  = rb_reg[k];
            assign qa_in  = qa_reg[k];
            assign qb_in  = qb_reg[k];
            assign den_in = den_reg[k];
            assign sb_in  = sb_reg[k];
        end

        assign cur_a  = {ra_in, na_in[NUM_W-1]};
        assign cur_b  = {rb_in, nb_in[NUM_W-1]};
        assign take_a = (cur_a >= {1'b0, den_in});
        assign take_b = (cur_b >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                ra_reg[k+1]  <= take_a ? DEN_W'(cur_a - {1'b0, den_in}) : DEN_W'(cur_a);
                rb_reg[k+1]  <= take_b ? DEN_W'(cur_b - {1'b0, den_in}) : DEN_W'(cur_b);
                qa_reg[k+1]  <= {qa_in[NUM_W-2:0], take_a};
                qb_reg[k+1]  <= {qb_in[NUM_W-2:0], take_b};
                na_reg[k+1]  <= {na_in[NUM_W-2:0], 1'b0};
                nbv_reg[k+1] <= {nb_in[NUM_W-2:0], 1'b0};
                den_reg[k+1] <= den_in;
                sb_reg[k+1]  <= sb_in;
            end
        end
    end

    assign out_vld = vld_reg[NUM_W];
    assign quo_a   = qa_reg[NUM_W];
    assign quo_b   = qb_reg[NUM_W];
    assign out_sb  = sb_reg[NUM_W];

endmodule

/* rtl/qrs_checker.sv */
module qrs_checker #(
    parameter int COEF_WIDTH = 32
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*COEF_WIDTH+4+7)/8)*8-1:0]   m_tdata
);
    import qrs_pkg::*;

    localparam int W = COEF_WIDTH;

    // a stalled result transaction holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side is free exactly when the output slot frees up
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output slot");

    // a zero leading coefficient reports nothing
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*W+2] |->
            m_tdata[1:0] == ROOTS_NONE && m_tdata[2*W+1:2] == '0 && !m_tdata[2*W+3])
        else $error("degenerate result carries roots");

    // the plus root is used only with two roots, and never a count of three
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ROOTS_NONE || m_tdata[1:0] == ROOTS_ONE ||
                      m_tdata[1:0] == ROOTS_TWO) &&
                     (m_tdata[1:0] == ROOTS_TWO || m_tdata[2*W+1:W+2] == '0))
        else $error("root count and roots disagree");

endmodule

bind quadratic_root_solver_top qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (.*);

/* sim/tb_quadratic_root_solver_top.sv */
`timescale 1ns / 100ps

import qrs_pkg::*;

// One solved coefficient set as it leaves the block
typedef struct {
    root_cnt_t   count;
    logic [31:0] r_minus;
    logic [31:0] r_plus;
    logic        degen;
    logic        sat;
} roots_t;

class root_scoreboard;
    roots_t pending[$];
    int     errors;
    int     checked;

    // Clamp a signed quotient into 32 bits
    function automatic logic [31:0] clamp_root(logic signed [127:0] q, ref logic sat);
        if (q > 128'sh7fffffff) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (q < -128'sh80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    // Floor square root of a nonnegative value
    function automatic logic [63:0] floor_sqrt(logic [127:0] d);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= d) r = c;
        end
        return r;
    endfunction

    // Root of numerator n over 2a, Q16.16, truncating toward zero
    function automatic logic [31:0] solve_root(logic signed [127:0] n,
                                               logic signed [127:0] a, ref logic sat);
        logic signed [127:0] q;
        q = (n <<< 16) / (2 * a);
        return clamp_root(q, sat);
    endfunction

    function void note_coefs(logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
        roots_t              e;
        logic signed [127:0] a, b, c, disc, s;
        a = $signed(ca);
        b = $signed(cb);
        c = $signed(cc);
        e.count = ROOTS_NONE;
        e.r_minus = '0;
        e.r_plus = '0;
        e.degen = 1'b0;
        e.sat = 1'b0;
        if (a == 0) begin
            e.degen = 1'b1;
        end else begin
            disc = b * b - 4 * a * c;
            if (disc == 0) begin
                e.count = ROOTS_ONE;
                e.r_minus = solve_root(-b, a, e.sat);
            end else if (disc > 0) begin
                s = $signed({64'd0, floor_sqrt(disc)});
                e.count = ROOTS_TWO;
                e.r_minus = solve_root(-b - s, a, e.sat);
                e.r_plus = solve_root(-b + s, a, e.sat);
            end
        end
        pending = {pending, e};
    endfunction

    function void check_roots(logic [71:0] d);
        roots_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", d);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (d[1:0] !== e.count || d[33:2] !== e.r_minus || d[65:34] !== e.r_plus
            || d[66] !== e.degen || d[67] !== e.sat || d[71:68] !== 4'd0) begin
            errors++;
            if (errors <= 10)
                $display(
                    "mismatch: exp cnt=%0d m=%h p=%h dg=%b st=%b, got cnt=%0d m=%h p=%h dg=%b st=%b",
                    e.count, e.r_minus, e.r_plus, e.degen, e.sat,
                    d[1:0], d[33:2], d[65:34], d[66], d[67]);
        end
    endfunction
endclass

module tb_quadratic_root_solver_top;
    localparam int LATENCY = 87;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    root_scoreboard sb;
    bit             calm;
    bit             sending_done;
    int             sent;

    quadratic_root_solver_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Send one coefficient set, with an occasional gap first
    task automatic send_coefs(logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cc, cb, ca};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_coefs(ca, cb, cc);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            4: return ($signed($urandom_range(0, 64)) - 32) <<< 16;
            default: return 32'($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // Roots p, q chosen first, so real roots with small content dominate
    task automatic send_from_roots();
        int p, q, k;
        p = $signed($urandom_range(0, 200)) - 100;
        q = $urandom_range(0, 3) == 0 ? p : $signed($urandom_range(0, 200)) - 100;
        k = $signed($urandom_range(1, 64)) * ($urandom_range(0, 1) ? 1 : -1);
        send_coefs(k <<< 16, (-k * (p + q)) <<< 16, (k * p * q) <<< 16);
    endtask

    // Sink side: random stalls in bursts
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_roots(m_tdata);
    end

    // Stimulus
    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: degenerate, negative, zero and positive discriminant, extremes
        send_coefs(32'h0, 32'h00010000, 32'h00010000);
        send_coefs(32'h0, 32'h0, 32'h0);
        send_coefs(32'h00010000, 32'h0, 32'h00010000);
        send_coefs(32'h00010000, 32'h00020000, 32'h00010000);
        send_coefs(32'h00010000, 32'h0, 32'hffff0000);
        send_coefs(32'hffff0000, 32'h00030000, 32'h00020000);
        send_coefs(32'h00000001, 32'h7fffffff, 32'h0);
        send_coefs(32'h00000001, 32'h80000000, 32'h0);
        send_coefs(32'h80000000, 32'h80000000, 32'h80000000);
        send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_coefs(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_coefs(32'h7fffffff, 32'h80000000, 32'h80000000);
        send_coefs(32'h00000001, 32'h00000000, 32'h80000000);
        send_coefs(32'hffffffff, 32'hffffffff, 32'h7fffffff);
        send_coefs(32'h00000001, 32'h00000002, 32'h00000001);
        send_coefs(32'hffffffff, 32'h0, 32'h0);
        send_coefs(32'h00010000, 32'h0, 32'h0);
        send_coefs(32'h00004000, 32'hffff0000, 32'h00010000);

        // Random: about a third factored polynomials, the rest raw patterns
        for (int i = 0; i < 830; i++) begin
            if (i == 700) calm = 1'b1;
            if ($urandom_range(0, 2) == 0) send_from_roots();
            else send_coefs(rand_coef(), rand_coef(), rand_coef());
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Drain and report
    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Solved %0d coefficient sets, %0d results checked", sent, sb.checked);
        $display("Covered degenerate, complex, repeated and saturating roots under stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end
endmodule
